>>> design/mfp_pkg.sv
// shared types and constants for the motor feedback frame parser
// no dependencies; used by the top level and the angle unwrap unit

package mfp_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_MOTOR_ID = 2'd0;
  localparam logic [1:0] CFG_INVERTED = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd2;

  // item commands
  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_DRIVE = 2'd2;

  // reset values and fixed constants
  localparam logic [9:0]  BASE_ID          = 10'd513;
  localparam logic [15:0] TIMEOUT_RESET    = 16'd100;
  localparam int          UNWRAP_W         = 45;

  // drive clamp limits
  localparam logic signed [31:0] DRIVE_HI_LIM = 32'sd32767;
  localparam logic signed [31:0] DRIVE_LO_LIM = -32'sd32768;
  localparam logic [15:0]        DRIVE_HI     = 16'h7fff;
  localparam logic [15:0]        DRIVE_LO     = 16'h8000;

  // request into the angle unwrap unit
  typedef struct packed {
    logic        take;
    logic        inverted;
    logic [15:0] raw;
  } angle_req_t;

endpackage

>>> design/mfp_angle_unwrap.sv
// encoder reduction, mirroring and revolution tracking
// depends on mfp_pkg (angle_req_t, UNWRAP_W)

module mfp_angle_unwrap #(
  parameter int ANGLE_STEPS = 8192,
  parameter int TURN_BITS   = 32,
  localparam int AW         = $clog2(ANGLE_STEPS)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mfp_pkg::angle_req_t            req_i,
  output logic [AW-1:0]                  angle_o,
  output logic [mfp_pkg::UNWRAP_W-1:0]   unwrapped_o
);

  localparam int UW = mfp_pkg::UNWRAP_W;
  // rounded-up inverse of ANGLE_STEPS, exact quotient for any 16-bit encoder
  localparam int          RS    = 16 + AW;
  localparam logic [17:0] RECIP =
    18'(((64'd1 << RS) + 64'(ANGLE_STEPS) - 64'd1) / 64'(ANGLE_STEPS));

  localparam logic [63:0] TURN_HALF = 64'd1 << (TURN_BITS - 1);
  localparam logic [63:0] STEPS_64  = 64'(ANGLE_STEPS);
  // accumulator values after the revolution counter wraps
  localparam logic [UW-1:0] ACC_AT_MIN = UW'(64'd0 - STEPS_64 * TURN_HALF);
  localparam logic [UW-1:0] ACC_AT_MAX = UW'(STEPS_64 * (TURN_HALF - 64'd1));
  localparam logic [UW-1:0] STEPS_UW   = UW'(ANGLE_STEPS);

  localparam logic [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS - 1){1'b1}}};
  localparam logic [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS - 1){1'b0}}};

  localparam logic signed [AW+1:0] HALF_S = (AW + 2)'(ANGLE_STEPS / 2);

  // reduction by reciprocal multiply, then one multiply back and a subtract
  function automatic logic [AW-1:0] reduce(input logic [15:0] enc);
    logic [33:0] prod;
    logic [16:0] quot;
    logic [16:0] back;
    prod = 34'(enc) * 34'(RECIP);
    quot = 17'(prod >> RS);
    back = quot * 17'(ANGLE_STEPS);
    return AW'({1'b0, enc} - back);
  endfunction

  logic [AW-1:0]        last_angle_q, last_angle_d;
  logic [TURN_BITS-1:0] turn_q, turn_d;
  logic [UW-1:0]        acc_q, acc_d;
  logic [UW-1:0]        unwrap_q, unwrap_d;
  logic [AW-1:0]        pos_red;
  logic [AW-1:0]        pos;
  logic signed [AW+1:0] diff;

  always_comb begin
    pos_red      = reduce(req_i.raw);
    pos          = req_i.inverted ? (AW'(ANGLE_STEPS - 1) - pos_red) : pos_red;
    diff         = $signed({2'b00, pos}) - $signed({2'b00, last_angle_q});
    last_angle_d = last_angle_q;
    turn_d       = turn_q;
    acc_d        = acc_q;
    if (req_i.take) begin
      last_angle_d = pos;
      if (diff < -HALF_S) begin
        turn_d = turn_q + TURN_BITS'(1);
        acc_d  = (turn_q == TURN_MAX) ? ACC_AT_MIN : acc_q + STEPS_UW;
      end else if (diff > HALF_S) begin
        turn_d = turn_q - TURN_BITS'(1);
        acc_d  = (turn_q == TURN_MIN) ? ACC_AT_MAX : acc_q - STEPS_UW;
      end
    end
    unwrap_d = UW'(last_angle_d) + acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_angle_q <= '0;
      turn_q       <= '0;
      acc_q        <= '0;
      unwrap_q     <= '0;
    end else if (req_i.take) begin
      last_angle_q <= last_angle_d;
      turn_q       <= turn_d;
      acc_q        <= acc_d;
      unwrap_q     <= unwrap_d;
    end
  end

  assign angle_o     = last_angle_q;
  assign unwrapped_o = unwrap_q;

endmodule

>>> design/motor_feedback_frame_parser.sv
// motor feedback frame parser: top level with input register and result state
// depends on mfp_pkg and mfp_angle_unwrap
//
// an accepted item passes the input register, then the result register, to its result
// throughput: one item per cycle while the output is not stalled; results are the state registers themselves
// reset: asynchronous, active low; readings, drive, countdown and turn counter clear,
// registers return to motor id 513, not inverted, timeout 100

module motor_feedback_frame_parser #(
  parameter int ANGLE_STEPS = 8192,
  parameter int TURN_BITS   = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // item input channel
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [1:0]   command_i,
  input  logic [10:0]  frame_id_i,
  input  logic [55:0]  frame_bytes_i,
  input  logic signed [31:0] drive_request_i,
  // result output channel
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic         frame_taken_o,
  output logic signed [15:0] speed_rpm_o,
  output logic signed [15:0] torque_value_o,
  output logic signed [7:0]  temperature_c_o,
  output logic [12:0]  angle_wrapped_o,
  output logic signed [44:0] angle_unwrapped_o,
  output logic         online_o,
  output logic signed [15:0] drive_value_o,
  output logic [1:0]   tx_slot_o,
  output logic [15:0]  tx_word_o,
  // configuration write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  localparam int AW = $clog2(ANGLE_STEPS);

  // configuration registers
  logic [9:0]  motor_id_q;
  logic        inverted_q;
  logic [15:0] timeout_q;

  // input register
  logic        in_valid_q;
  logic [1:0]  command_q;
  logic [10:0] frame_id_q;
  logic [55:0] frame_bytes_q;
  logic signed [31:0] drive_request_q;

  // result state
  logic        out_valid_q;
  logic        taken_q, taken_d;
  logic [15:0] speed_q, speed_d;
  logic [15:0] torque_q, torque_d;
  logic [7:0]  temp_q, temp_d;
  logic [15:0] drive_q, drive_d;
  logic [15:0] countdown_q, countdown_d;
  logic        running_q, running_d;

  logic        advance;
  logic        match;
  logic [15:0] spd_raw;
  logic [15:0] trq_raw;
  logic [15:0] clamped;

  mfp_pkg::angle_req_t angle_req;
  logic [AW-1:0]       angle;
  logic [44:0]         unwrapped;

  // item moves from the input register into the result state when the result slot frees
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_id_q <= mfp_pkg::BASE_ID;
      inverted_q <= 1'b0;
      timeout_q  <= mfp_pkg::TIMEOUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mfp_pkg::CFG_MOTOR_ID: motor_id_q <= cfg_data_i[9:0];
        mfp_pkg::CFG_INVERTED: inverted_q <= cfg_data_i[0];
        mfp_pkg::CFG_TIMEOUT:  timeout_q  <= cfg_data_i;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // input register: control bit reset, payload loads only on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      command_q       <= command_i;
      frame_id_q      <= frame_id_i;
      frame_bytes_q   <= frame_bytes_i;
      drive_request_q <= drive_request_i;
    end
  end

  assign match   = (command_q == mfp_pkg::CMD_FRAME) && (frame_id_q == {1'b0, motor_id_q});
  // big-endian fields: encoder in bytes 0-1, speed 2-3, torque 4-5, temperature 6
  assign spd_raw = frame_bytes_q[39:24];
  assign trq_raw = frame_bytes_q[23:8];

  // clamp the drive request to the 16-bit signed range
  always_comb begin
    if (drive_request_q < mfp_pkg::DRIVE_LO_LIM) begin
      clamped = mfp_pkg::DRIVE_LO;
    end else if (drive_request_q > mfp_pkg::DRIVE_HI_LIM) begin
      clamped = mfp_pkg::DRIVE_HI;
    end else begin
      clamped = drive_request_q[15:0];
    end
  end

  always_comb begin
    taken_d     = 1'b0;
    speed_d     = speed_q;
    torque_d    = torque_q;
    temp_d      = temp_q;
    drive_d     = drive_q;
    countdown_d = countdown_q;
    running_d   = running_q;
    case (command_q)
      mfp_pkg::CMD_FRAME: begin
        if (match) begin
          taken_d     = 1'b1;
          speed_d     = inverted_q ? (16'd0 - spd_raw) : spd_raw;
          torque_d    = inverted_q ? (16'd0 - trq_raw) : trq_raw;
          temp_d      = frame_bytes_q[7:0];
          countdown_d = timeout_q;
          running_d   = 1'b1;
        end
      end
      mfp_pkg::CMD_TICK: begin
        // countdown stops at zero; a stopped timer ignores ticks
        if (running_q && (countdown_q != '0)) begin
          countdown_d = countdown_q - 16'd1;
        end
      end
      mfp_pkg::CMD_DRIVE: begin
        drive_d = inverted_q ? (16'd0 - clamped) : clamped;
      end
      default: ;  // unused command leaves the state alone
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      taken_q     <= 1'b0;
      speed_q     <= '0;
      torque_q    <= '0;
      temp_q      <= '0;
      drive_q     <= '0;
      countdown_q <= '0;
      running_q   <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        taken_q     <= taken_d;
        speed_q     <= speed_d;
        torque_q    <= torque_d;
        temp_q      <= temp_d;
        drive_q     <= drive_d;
        countdown_q <= countdown_d;
        running_q   <= running_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // encoder path updates on the same edge as the rest of the frame state
  assign angle_req.take     = advance && match;
  assign angle_req.inverted = inverted_q;
  assign angle_req.raw      = frame_bytes_q[55:40];

  mfp_angle_unwrap #(
    .ANGLE_STEPS (ANGLE_STEPS),
    .TURN_BITS   (TURN_BITS)
  ) u_unwrap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (angle_req),
    .angle_o     (angle),
    .unwrapped_o (unwrapped)
  );

  // results read straight from the state; it only moves when the slot is free
  assign out_valid_o       = out_valid_q;
  assign frame_taken_o     = taken_q;
  assign speed_rpm_o       = speed_q;
  assign torque_value_o    = torque_q;
  assign temperature_c_o   = temp_q;
  assign angle_wrapped_o   = 13'(angle);
  assign angle_unwrapped_o = unwrapped;
  assign online_o          = running_q && (countdown_q != '0);
  assign drive_value_o     = drive_q;
  // transmit word slot from the id offset
  assign tx_slot_o         = 2'(motor_id_q - mfp_pkg::BASE_ID);
  assign tx_word_o         = drive_q;

endmodule

>>> design/mfp_checker.sv
// port-level checks for the motor feedback frame parser
// depends on motor_feedback_frame_parser ports; bound to the top level below

module mfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        frame_taken_o,
  input logic [15:0] drive_value_o,
  input logic [44:0] angle_unwrapped_o,
  input logic [1:0]  tx_slot_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  // a held result keeps its fields
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(frame_taken_o) && $stable(drive_value_o) && $stable(angle_unwrapped_o))
    else $error("result changed while stalled");

  // input never backs up while the result slot is empty
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result slot");

  // an accepted item reaches the output, through the input register, when the slot is free
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 (!out_valid_o || !out_stall_i) |=> out_valid_o)
    else $error("accepted item did not produce a result");

  // the transmit slot moves only after a configuration write
  a_slot_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_valid_i && cfg_ready_o) |=> $stable(tx_slot_o))
    else $error("tx slot changed without a write");

endmodule

bind motor_feedback_frame_parser mfp_checker u_mfp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .frame_taken_o     (frame_taken_o),
  .drive_value_o     (drive_value_o),
  .angle_unwrapped_o (angle_unwrapped_o),
  .tx_slot_o         (tx_slot_o),
  .cfg_valid_i       (cfg_valid_i),
  .cfg_ready_o       (cfg_ready_o)
);
